// ===== src/dtfp_pkg.sv =====
// Shared types, constants and the power-of-ten table for the decimal text to fixed-point block.
package dtfp_pkg;

    localparam int FIXED_W             = 32;
    localparam int CHAR_W              = 8;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int MAX_FRAC_DIGITS_DEF = 9;
    localparam int FRAC_ACC_W          = 30;
    localparam int DIGIT_CNT_W         = 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    typedef struct packed {
        logic take;
        logic load;
        logic step;
        logic finish;
    } dtfp_cmd_t;

    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [DIGIT_CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        case (n)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/dtfp_ctrl.sv =====
// Controller: handshakes, parse, division and output sequencing.
module dtfp_ctrl #(
    parameter int FRAC_BITS = dtfp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              last_char,
    output logic              out_valid,
    input  logic              out_ready,
    output dtfp_pkg::dtfp_cmd_t cmd
);
    import dtfp_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);

    typedef enum logic [2:0] {
        ST_PARSE,
        ST_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   step_cnt_reg, step_cnt_next;
    logic               take;

    always_comb
    begin
        case (state_reg)
            ST_PARSE: in_ready = 1'b1;
            ST_OUT:   in_ready = out_ready || !last_char;
            default:  in_ready = 1'b0;
        endcase
    end

    assign take      = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        cmd.take      = take;
        cmd.load      = (state_reg == ST_LOAD);
        cmd.step      = (state_reg == ST_DIV);
        cmd.finish    = (state_reg == ST_FINISH);
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            ST_PARSE:
            begin
                if (take && last_char)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == CNT_W'(FRAC_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (take && last_char) ? ST_LOAD : ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_PARSE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

endmodule

// ===== src/dtfp_datapath.sv =====
// Datapath: character accumulators, fraction divider and result registers.
module dtfp_datapath #(
    parameter int FRAC_BITS       = dtfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dtfp_pkg::dtfp_cmd_t                  cmd,
    input  logic [dtfp_pkg::CHAR_W-1:0]          char_code,
    output logic signed [dtfp_pkg::FIXED_W-1:0]  fixed_value,
    output logic                                 saturated,
    output logic                                 saw_digit
);
    import dtfp_pkg::*;

    localparam int INT_W = FIXED_W - FRAC_BITS;
    localparam int MAG_W = FIXED_W + 1;

    localparam logic [1:0] SIGN_NONE    = 2'd0;
    localparam logic [1:0] SIGN_POS     = 2'd1;
    localparam logic [1:0] SIGN_NEG     = 2'd2;
    localparam logic [1:0] SIGN_NEG_DIG = 2'd3;

    localparam logic [MAG_W-1:0] LIMIT_POS = 33'h07FFFFFFF;
    localparam logic [MAG_W-1:0] LIMIT_NEG = 33'h080000000;

    logic [INT_W-1:0]       int_acc_reg, int_acc_next;
    logic                   int_ovf_reg, int_ovf_next;
    logic [FRAC_ACC_W-1:0]  frac_acc_reg, frac_acc_next;
    logic [DIGIT_CNT_W-1:0] frac_cnt_reg, frac_cnt_next;
    logic [1:0]             sign_reg, sign_next;
    logic                   in_frac_reg, in_frac_next;
    logic                   done_reg, done_next;

    logic [FRAC_ACC_W-1:0]  rem_reg;
    logic [FRAC_ACC_W-1:0]  divisor_reg;
    logic [FRAC_BITS-1:0]   quot_reg;
    logic [FRAC_ACC_W:0]    rem_shift;
    logic                   rem_ge;

    logic signed [FIXED_W-1:0] fixed_value_reg;
    logic                      saturated_reg;
    logic                      saw_digit_reg;

    logic [INT_W+3:0]       int_prod;
    logic [FRAC_ACC_W+3:0]  frac_prod;
    logic [3:0]             digit;
    logic                   is_digit;

    logic                   has_digit;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [MAG_W-1:0]       limit;
    logic                   sat;
    logic [FIXED_W-1:0]     mag_clamped;

    assign digit     = 4'(char_code - CHAR_ZERO);
    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign int_prod  = ({4'b0, int_acc_reg} << 3) + ({4'b0, int_acc_reg} << 1)
                       + (INT_W + 4)'(digit);
    assign frac_prod = ({4'b0, frac_acc_reg} << 3) + ({4'b0, frac_acc_reg} << 1)
                       + (FRAC_ACC_W + 4)'(digit);

    always_comb
    begin
        int_acc_next  = int_acc_reg;
        int_ovf_next  = int_ovf_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        sign_next     = sign_reg;
        in_frac_next  = in_frac_reg;
        done_next     = done_reg;
        if (cmd.finish)
        begin
            int_acc_next  = '0;
            int_ovf_next  = 1'b0;
            frac_acc_next = '0;
            frac_cnt_next = '0;
            sign_next     = SIGN_NONE;
            in_frac_next  = 1'b0;
            done_next     = 1'b0;
        end
        else if (cmd.take && !done_reg && char_code != CHAR_SPACE)
        begin
            if (char_code == CHAR_NUL)
            begin
                done_next = 1'b1;
            end
            else if (char_code == CHAR_MINUS && sign_reg == SIGN_NONE)
            begin
                sign_next = SIGN_NEG;
            end
            else if (char_code == CHAR_POINT && !in_frac_reg)
            begin
                in_frac_next = 1'b1;
            end
            else if (!is_digit)
            begin
                done_next = 1'b1;
            end
            else
            begin
                if (sign_reg == SIGN_NONE)
                begin
                    sign_next = SIGN_POS;
                end
                else if (sign_reg == SIGN_NEG)
                begin
                    sign_next = SIGN_NEG_DIG;
                end
                if (in_frac_reg)
                begin
                    if (frac_cnt_reg < DIGIT_CNT_W'(MAX_FRAC_DIGITS))
                    begin
                        frac_acc_next = frac_prod[FRAC_ACC_W-1:0];
                        frac_cnt_next = frac_cnt_reg + 1'b1;
                    end
                end
                else if (!int_ovf_reg)
                begin
                    if (int_prod[INT_W+3:INT_W] != 4'd0)
                    begin
                        int_ovf_next = 1'b1;
                        int_acc_next = '1;
                    end
                    else
                    begin
                        int_acc_next = int_prod[INT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_acc_reg  <= '0;
            int_ovf_reg  <= 1'b0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
            sign_reg     <= SIGN_NONE;
            in_frac_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            int_acc_reg  <= int_acc_next;
            int_ovf_reg  <= int_ovf_next;
            frac_acc_reg <= frac_acc_next;
            frac_cnt_reg <= frac_cnt_next;
            sign_reg     <= sign_next;
            in_frac_reg  <= in_frac_next;
            done_reg     <= done_next;
        end
    end

    // Restoring division: one quotient bit of the scaled fraction per cycle.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg     <= frac_acc_reg;
            divisor_reg <= pow10(frac_cnt_reg);
            quot_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_ge ? FRAC_ACC_W'(rem_shift - {1'b0, divisor_reg})
                               : rem_shift[FRAC_ACC_W-1:0];
            quot_reg <= {quot_reg[FRAC_BITS-2:0], rem_ge};
        end
    end

    assign has_digit   = (sign_reg == SIGN_POS) || (sign_reg == SIGN_NEG_DIG);
    assign neg         = (sign_reg == SIGN_NEG_DIG);
    assign mag         = {1'b0, int_acc_reg, {FRAC_BITS{1'b0}}}
                         + {{(MAG_W - FRAC_BITS){1'b0}}, quot_reg};
    assign limit       = neg ? LIMIT_NEG : LIMIT_POS;
    assign sat         = has_digit && (int_ovf_reg || (mag > limit));
    assign mag_clamped = sat ? limit[FIXED_W-1:0] : mag[FIXED_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            saturated_reg <= sat;
            saw_digit_reg <= has_digit;
            if (!has_digit)
            begin
                fixed_value_reg <= '0;
            end
            else if (neg)
            begin
                fixed_value_reg <= signed'(FIXED_W'(0) - mag_clamped);
            end
            else
            begin
                fixed_value_reg <= signed'(mag_clamped);
            end
        end
    end

    assign fixed_value = fixed_value_reg;
    assign saturated   = saturated_reg;
    assign saw_digit   = saw_digit_reg;

endmodule

// ===== src/decimal_text_to_fixed_point.sv =====
// Top level of the decimal text to signed fixed-point converter.
//
// The input channel (in_valid, in_ready) carries one character per transfer in
// char_code, with last_char set on the final character of a number string.
// Ordinary characters are taken one per cycle while in_ready is high and folded
// into the integer and fraction accumulators in that same cycle.
// After the transfer of the final character the block loads its divider, forms
// one bit of the binary fraction per cycle in the bit-serial divider, then
// clamps and signs the value, and the result appears on the output channel
// (out_valid, out_ready).
// While a result waits, the characters of the next string are still taken;
// only its final character waits until the result has been transferred.
// in_ready stays low while the divider is loaded, runs and finishes the value.
// Reset clears all accumulators and leaves the block ready for a new string
// with no result pending.
module decimal_text_to_fixed_point #(
    parameter int FRAC_BITS       = dtfp_pkg::FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = dtfp_pkg::MAX_FRAC_DIGITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [dtfp_pkg::CHAR_W-1:0]          char_code,
    input  logic                                 last_char,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dtfp_pkg::FIXED_W-1:0]  fixed_value,
    output logic                                 saturated,
    output logic                                 saw_digit
);
    import dtfp_pkg::*;

    dtfp_cmd_t cmd;

    dtfp_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dtfp_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .char_code   (char_code),
        .fixed_value (fixed_value),
        .saturated   (saturated),
        .saw_digit   (saw_digit)
    );

endmodule
